>>> hw/rtl/multiword_schoolbook_multiplier_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multiword schoolbook multiplier unit
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef MULTIWORD_SCHOOLBOOK_MULTIPLIER_UNIT_MACROS_SVH
`define MULTIWORD_SCHOOLBOOK_MULTIPLIER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/msm_pkg.sv
// ----------------------------------------------------------------------------
// msm_pkg
// Constants, payload types and control bundle of the multiword multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package msm_pkg;

    localparam int MAX_WORDS = 16;
    localparam int WORD_BITS = 32;

    // Address and count widths derived from the store depths.
    localparam int A_W   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int PA_W  = $clog2(2 * MAX_WORDS);
    localparam int CNT_W = $clog2(MAX_WORDS + 1);

    // Fixed field widths of the command and result transfers.
    localparam int KIND_W  = 2;
    localparam int WIDX_W  = 4;
    localparam int VAL_W   = 32;
    localparam int LEN_W   = 5;
    localparam int PIDX_W  = 5;
    localparam int USED_W  = 6;

    localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WIDX_W-1:0] word_index;
        logic [VAL_W-1:0]  word_value;
        logic [LEN_W-1:0]  first_length;
        logic [LEN_W-1:0]  second_length;
    } msm_cmd_t;

    typedef struct packed {
        logic [VAL_W-1:0]  product_word;
        logic [PIDX_W-1:0] product_index;
        logic [USED_W-1:0] used_length;
        logic              last;
    } msm_res_t;

    // Control from the sequencer to the product store.
    typedef struct packed {
        logic            clear;       // a multiply starts: reset the trimmed length
        logic            issue;       // one word product enters the pipeline
        logic [PA_W-1:0] addr;        // product store read address (and carry write)
        logic            row0;        // first row: the product word reads as zero
        logic            first;       // first column of a row: no carry in
        logic            final_pos;   // this write settles its product word
        logic            carry_wr;    // write the row's carry out at addr
        logic            carry_final; // the carry write settles its product word
    } msm_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/msm_operand_store.sv
// ----------------------------------------------------------------------------
// msm_operand_store
// Two operand word memories with one write port each side and registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module msm_operand_store (
    input  wire logic                          clk,
    input  wire logic                          wr_en_a,
    input  wire logic                          wr_en_b,
    input  wire logic [msm_pkg::A_W-1:0]       wr_addr,
    input  wire logic [msm_pkg::WORD_BITS-1:0] wr_data,
    input  wire logic [msm_pkg::A_W-1:0]       rd_addr_a,
    input  wire logic [msm_pkg::A_W-1:0]       rd_addr_b,
    output logic      [msm_pkg::WORD_BITS-1:0] rd_a,
    output logic      [msm_pkg::WORD_BITS-1:0] rd_b
);
    import msm_pkg::*;

    logic [WORD_BITS-1:0] a_mem [MAX_WORDS];
    logic [WORD_BITS-1:0] b_mem [MAX_WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en_a)
        begin
            a_mem[wr_addr] <= wr_data;
        end
        rd_a <= a_mem[rd_addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en_b)
        begin
            b_mem[wr_addr] <= wr_data;
        end
        rd_b <= b_mem[rd_addr_b];
    end

endmodule

`default_nettype wire

>>> hw/rtl/msm_product_store.sv
// ----------------------------------------------------------------------------
// msm_product_store
// Product word memory with the multiply-accumulate pipeline that updates it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multiword_schoolbook_multiplier_unit_macros.svh"

module msm_product_store (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire msm_pkg::msm_ctl_t             ctl,
    input  wire logic [msm_pkg::WORD_BITS-1:0] a_word,
    input  wire logic [msm_pkg::WORD_BITS-1:0] b_word,
    output logic      [msm_pkg::WORD_BITS-1:0] rd_data,
    output logic      [msm_pkg::PA_W:0]        used
);
    import msm_pkg::*;

    logic [WORD_BITS-1:0] p_mem [2 * MAX_WORDS];

    // Stage 1: operand and product words arrive from the memories.
    logic            s1_v_reg;
    logic [PA_W-1:0] s1_addr_reg;
    logic            s1_row0_reg;
    logic            s1_first_reg;
    logic            s1_final_reg;

    // Stage 2: the partial product is added into the product word.
    logic                   s2_v_reg;
    logic [PA_W-1:0]        s2_addr_reg;
    logic                   s2_first_reg;
    logic                   s2_final_reg;
    logic [2*WORD_BITS-1:0] mul_reg;
    logic [WORD_BITS-1:0]   addend_reg;
    logic [WORD_BITS-1:0]   carry_reg;
    logic [PA_W:0]          used_reg;
    logic [PA_W:0]          used_next;

    logic [2*WORD_BITS-1:0] a_ext;
    logic [2*WORD_BITS-1:0] b_ext;
    logic [2*WORD_BITS-1:0] sum;
    logic [WORD_BITS-1:0]   cin;

    assign a_ext = {{WORD_BITS{1'b0}}, a_word};
    assign b_ext = {{WORD_BITS{1'b0}}, b_word};
    assign cin   = s2_first_reg ? '0 : carry_reg;
    // The sum of a full word product and two words never exceeds two words.
    assign sum   = mul_reg + {{WORD_BITS{1'b0}}, addend_reg} + {{WORD_BITS{1'b0}}, cin};

    always_ff @(posedge clk)
    begin
        rd_data <= p_mem[ctl.addr];
        if (s2_v_reg)
        begin
            p_mem[s2_addr_reg] <= sum[WORD_BITS-1:0];
        end
        else if (ctl.carry_wr)
        begin
            p_mem[ctl.addr] <= carry_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            used_reg <= '0;
        end
        else
        begin
            s1_v_reg <= ctl.issue;
            s2_v_reg <= s1_v_reg;
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= ctl.addr;
        s1_row0_reg  <= ctl.row0;
        s1_first_reg <= ctl.first;
        s1_final_reg <= ctl.final_pos;
        s2_addr_reg  <= s1_addr_reg;
        s2_first_reg <= s1_first_reg;
        s2_final_reg <= s1_final_reg;
        mul_reg      <= a_ext * b_ext;
        // The first row overwrites stale words, so the store needs no clearing.
        addend_reg   <= s1_row0_reg ? '0 : rd_data;
        if (s2_v_reg)
        begin
            carry_reg <= sum[2*WORD_BITS-1:WORD_BITS];
        end
    end

    // Product words settle in ascending order, so the last nonzero one sets the length.
    always_comb
    begin
        used_next = used_reg;
        if (ctl.clear)
        begin
            used_next = '0;
        end
        else if (s2_v_reg && s2_final_reg && (sum[WORD_BITS-1:0] != '0))
        begin
            used_next = (PA_W + 1)'(s2_addr_reg) + (PA_W + 1)'(1);
        end
        else if (ctl.carry_wr && ctl.carry_final && (carry_reg != '0))
        begin
            used_next = (PA_W + 1)'(ctl.addr) + (PA_W + 1)'(1);
        end
    end

    assign used = used_reg;

    `MSM_ASSERT_SAME(a_wr_port_free, s2_v_reg, !ctl.carry_wr, "carry write collides with MAC write")
    `MSM_ASSERT_NEXT(a_clear_used, ctl.clear, used_reg == '0, "trimmed length not cleared at start")
    `MSM_ASSERT_NEXT(a_pipe_advance, s1_v_reg, s2_v_reg, "word product lost in the pipeline")

endmodule

`default_nettype wire

>>> hw/rtl/multiword_schoolbook_multiplier_unit.sv
// ----------------------------------------------------------------------------
// multiword_schoolbook_multiplier_unit
// Multiword unsigned schoolbook multiplier with word stores and word output.
// ----------------------------------------------------------------------------
// A command transfer takes place at a clock edge where start is high and busy
// is low. A multiply of m by n words runs the accumulate states when both
// lengths are nonzero (none otherwise), then sends out every product word (a
// single word if m+n is zero); the single multiply-accumulate pipeline through
// the product store takes one word product per cycle within a row, with the
// drain states DR1 and DR2 and a carry write closing each row. Product words
// then leave one per cycle, lowest first, each marked by done for exactly one
// cycle: the receiver cannot stall, so it must take every word as it appears.
// The last word appears in the first cycle with busy low again. The product
// store needs no clearing pass, since the first row writes every word it later reads.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multiword_schoolbook_multiplier_unit_macros.svh"

module multiword_schoolbook_multiplier_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire msm_pkg::msm_cmd_t command,
    output logic                   done,
    output msm_pkg::msm_res_t      result
);
    import msm_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_DR1   = 3'd2;
    localparam logic [2:0] ST_DR2   = 3'd3;
    localparam logic [2:0] ST_CARRY = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [A_W-1:0]   i_reg, i_next;
    logic [A_W-1:0]   j_reg, j_next;
    logic [PA_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0] m_reg, m_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [PA_W:0]    total_reg, total_next;
    logic             zero_reg, zero_next;
    logic             out_v_reg;
    logic [PA_W-1:0]  k_dly_reg;
    logic             last_dly_reg;

    logic                 accept;
    logic                 load_ok;
    logic [CNT_W-1:0]     m_sat;
    logic [CNT_W-1:0]     n_sat;
    logic                 row_last;
    logic                 col_last;
    logic                 k_last;
    msm_ctl_t             ctl;
    logic [WORD_BITS-1:0] a_word;
    logic [WORD_BITS-1:0] b_word;
    logic [WORD_BITS-1:0] p_word;
    logic [PA_W:0]        used;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign load_ok = (32'(command.word_index) < MAX_WORDS);
    assign m_sat   = (32'(command.first_length) > MAX_WORDS) ? CNT_W'(MAX_WORDS)
                                                             : CNT_W'(command.first_length);
    assign n_sat   = (32'(command.second_length) > MAX_WORDS) ? CNT_W'(MAX_WORDS)
                                                              : CNT_W'(command.second_length);
    assign row_last = ((CNT_W'(j_reg) + CNT_W'(1)) == m_reg);
    assign col_last = ((CNT_W'(i_reg) + CNT_W'(1)) == n_reg);
    assign k_last   = (total_reg == '0) || (((PA_W + 1)'(k_reg) + (PA_W + 1)'(1)) == total_reg);

    msm_operand_store u_operands (
        .clk       (clk),
        .wr_en_a   (accept && (command.kind == KIND_LOAD_A) && load_ok),
        .wr_en_b   (accept && (command.kind == KIND_LOAD_B) && load_ok),
        .wr_addr   (A_W'(command.word_index)),
        .wr_data   (WORD_BITS'(command.word_value)),
        .rd_addr_a (j_reg),
        .rd_addr_b (i_reg),
        .rd_a      (a_word),
        .rd_b      (b_word)
    );

    msm_product_store u_product (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .a_word  (a_word),
        .b_word  (b_word),
        .rd_data (p_word),
        .used    (used)
    );

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        m_next     = m_reg;
        n_next     = n_reg;
        total_next = total_reg;
        zero_next  = zero_reg;

        ctl             = '0;
        ctl.clear       = accept && (command.kind == KIND_START);
        ctl.row0        = (j_reg == '0);
        ctl.first       = (i_reg == '0);
        ctl.final_pos   = (i_reg == '0) || row_last;
        ctl.carry_final = row_last;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (command.kind == KIND_START))
                begin
                    m_next     = m_sat;
                    n_next     = n_sat;
                    total_next = (PA_W + 1)'(m_sat) + (PA_W + 1)'(n_sat);
                    zero_next  = (m_sat == '0) || (n_sat == '0);
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ((m_sat == '0) || (n_sat == '0)) ? ST_OUT : ST_MUL;
                end
            end
            ST_MUL:
            begin
                ctl.issue = 1'b1;
                ctl.addr  = PA_W'(i_reg) + PA_W'(j_reg);
                if (col_last)
                begin
                    state_next = ST_DR1;
                end
                else
                begin
                    i_next = i_reg + A_W'(1);
                end
            end
            ST_DR1:
            begin
                state_next = ST_DR2;
            end
            ST_DR2:
            begin
                state_next = ST_CARRY;
            end
            ST_CARRY:
            begin
                ctl.carry_wr = 1'b1;
                ctl.addr     = PA_W'(j_reg) + PA_W'(n_reg);
                i_next       = '0;
                if (row_last)
                begin
                    k_next     = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    j_next     = j_reg + A_W'(1);
                    state_next = ST_MUL;
                end
            end
            ST_OUT:
            begin
                ctl.addr = k_reg;
                if (k_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next = k_reg + PA_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_v_reg <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            m_reg     <= '0;
            n_reg     <= '0;
            total_reg <= '0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_v_reg <= (state_reg == ST_OUT);
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            m_reg     <= m_next;
            n_reg     <= n_next;
            total_reg <= total_next;
            zero_reg  <= zero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_dly_reg    <= k_reg;
        last_dly_reg <= k_last;
    end

    // With an empty operand the store holds stale words, so zeros go out instead.
    assign done                 = out_v_reg;
    assign result.product_word  = zero_reg ? '0 : VAL_W'(p_word);
    assign result.product_index = PIDX_W'(k_dly_reg);
    assign result.used_length   = USED_W'(used);
    assign result.last          = last_dly_reg;

    `MSM_ASSERT_SAME(a_mid_word_busy, done && !result.last, busy, "product word out while idle")
    `MSM_ASSERT_NEXT(a_single_last, done && result.last, !done, "transfer follows the last word")
    `MSM_ASSERT_NEXT(a_start_busy, accept && (command.kind == KIND_START), busy, "multiply not begun")

endmodule

`default_nettype wire

>>> verif/multiword_schoolbook_multiplier_unit_tb.sv
// ----------------------------------------------------------------------------
// multiword_schoolbook_multiplier_unit_tb
// Self-checking bench for the multiword multiplier. Operand words are loaded
// and multiplies started through the start/busy command transfer. Each
// product word seen on the done strobe is compared with a schoolbook product
// that the bench works out from its own copy of the operand stores.
// ----------------------------------------------------------------------------

class product_tracker;

    bit [msm_pkg::VAL_W-1:0] first_words  [msm_pkg::MAX_WORDS];
    bit [msm_pkg::VAL_W-1:0] second_words [msm_pkg::MAX_WORDS];
    msm_pkg::msm_res_t       pending_words[$];
    int unsigned             mismatches;

    function new();
        mismatches = 0;
    endfunction

    // Lengths above the store depth saturate to the store depth.
    function int clip_length(bit [msm_pkg::LEN_W-1:0] len);
        return (len > msm_pkg::MAX_WORDS) ? msm_pkg::MAX_WORDS : int'(len);
    endfunction

    function void queue_product(int m, int n);
        bit [msm_pkg::VAL_W-1:0] prod [2*msm_pkg::MAX_WORDS];
        bit [63:0]               acc;
        bit [msm_pkg::VAL_W-1:0] carry;
        int                      total;
        int                      used;
        msm_pkg::msm_res_t       word;
        foreach (prod[k])
            prod[k] = '0;
        for (int j = 0; j < m; j++)
        begin
            carry = '0;
            for (int i = 0; i < n; i++)
            begin
                acc = 64'(prod[i+j]) + 64'(first_words[j]) * 64'(second_words[i])
                    + 64'(carry);
                prod[i+j] = acc[31:0];
                carry     = acc[63:32];
            end
            // Row j never touched position j+n before, so the carry out lands there.
            prod[j+n] = carry;
        end
        total = m + n;
        if (total == 0)
        begin
            word.product_word  = '0;
            word.product_index = '0;
            word.used_length   = '0;
            word.last          = 1'b1;
            pending_words.push_back(word);
            return;
        end
        used = total;
        while (used > 0 && prod[used-1] == '0)
            used--;
        for (int i = 0; i < total; i++)
        begin
            word.product_word  = prod[i];
            word.product_index = msm_pkg::PIDX_W'(i);
            word.used_length   = msm_pkg::USED_W'(used);
            word.last          = (i + 1 == total);
            pending_words.push_back(word);
        end
    endfunction

    function void note_command(msm_pkg::msm_cmd_t cmd);
        if (cmd.kind == msm_pkg::KIND_LOAD_A)
        begin
            if (cmd.word_index < msm_pkg::MAX_WORDS)
                first_words[cmd.word_index] = cmd.word_value;
        end
        else if (cmd.kind == msm_pkg::KIND_LOAD_B)
        begin
            if (cmd.word_index < msm_pkg::MAX_WORDS)
                second_words[cmd.word_index] = cmd.word_value;
        end
        else if (cmd.kind == msm_pkg::KIND_START)
            queue_product(clip_length(cmd.first_length), clip_length(cmd.second_length));
    endfunction

    function void check_word(msm_pkg::msm_res_t got);
        msm_pkg::msm_res_t want;
        if (pending_words.size() == 0)
        begin
            $error("unexpected product word: index %0d, value %h",
                   got.product_index, got.product_word);
            mismatches++;
            return;
        end
        want = pending_words.pop_front();
        if (got.product_word !== want.product_word)
        begin
            $error("product_word: expected %h, actual %h", want.product_word, got.product_word);
            mismatches++;
        end
        if (got.product_index !== want.product_index)
        begin
            $error("product_index: expected %0d, actual %0d",
                   want.product_index, got.product_index);
            mismatches++;
        end
        if (got.used_length !== want.used_length)
        begin
            $error("used_length: expected %0d, actual %0d", want.used_length, got.used_length);
            mismatches++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            mismatches++;
        end
    endfunction

endclass

module multiword_schoolbook_multiplier_unit_tb;

    import msm_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int                CMD_W       = $bits(msm_cmd_t);

    logic      clk = 1'b0;
    logic      rst_n;
    logic      start;
    logic      busy;
    msm_cmd_t  command;
    logic      done;
    msm_res_t  result;

    product_tracker      tracker = new();
    bit [MAX_WORDS-1:0]  first_loaded;
    bit [MAX_WORDS-1:0]  second_loaded;
    int unsigned         sender_idle_pct;
    int unsigned         items_sent;
    int unsigned         sequence_count;

    multiword_schoolbook_multiplier_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .done    (done),
        .result  (result)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            tracker.check_word(result);
    end

    // Holds the command until a transfer happens, then idles at random.
    task automatic transfer(msm_cmd_t cmd);
        start   <= 1'b1;
        command <= cmd;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        tracker.note_command(cmd);
        if (cmd.kind != KIND_UNUSED)
            items_sent++;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start   <= 1'b0;
            command <= msm_cmd_t'(CMD_W'({$urandom(), $urandom()}));
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    task automatic load_word(logic [KIND_W-1:0] kind, int idx, bit [VAL_W-1:0] value);
        msm_cmd_t cmd;
        cmd.kind          = kind;
        cmd.word_index    = WIDX_W'(idx);
        cmd.word_value    = value;
        cmd.first_length  = LEN_W'($urandom_range(31));
        cmd.second_length = LEN_W'($urandom_range(31));
        if (kind == KIND_LOAD_A)
            first_loaded[idx] = 1'b1;
        else
            second_loaded[idx] = 1'b1;
        transfer(cmd);
    endtask

    task automatic multiply(bit [LEN_W-1:0] m_field, bit [LEN_W-1:0] n_field);
        msm_cmd_t cmd;
        cmd.kind          = KIND_START;
        cmd.word_index    = WIDX_W'($urandom_range(15));
        cmd.word_value    = $urandom();
        cmd.first_length  = m_field;
        cmd.second_length = n_field;
        transfer(cmd);
    endtask

    task automatic send_noise();
        msm_cmd_t cmd;
        cmd               = msm_cmd_t'(CMD_W'({$urandom(), $urandom()}));
        cmd.kind          = KIND_UNUSED;
        transfer(cmd);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (tracker.pending_words.size() != 0)
            @(posedge clk);
    endtask

    function automatic bit [VAL_W-1:0] pick_word();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return VAL_W'(1) << $urandom_range(31);
            default: return $urandom();
        endcase
    endfunction

    function automatic int pick_size();
        int r;
        r = $urandom_range(15);
        if (r < 10)
            return $urandom_range(4);
        else if (r < 14)
            return $urandom_range(10, 5);
        return MAX_WORDS;
    endfunction

    function automatic int loaded_prefix(bit [MAX_WORDS-1:0] flags);
        int k;
        k = 0;
        while (k < MAX_WORDS && flags[k])
            k++;
        return k;
    endfunction

    // A full-size length may be given as any value up to the field maximum.
    function automatic bit [LEN_W-1:0] length_field(int size);
        if (size == MAX_WORDS && $urandom_range(1))
            return LEN_W'($urandom_range(31, MAX_WORDS + 1));
        return LEN_W'(size);
    endfunction

    task automatic run_sequence(bit full_size);
        int m;
        int n;
        int idx;
        bit reverse;
        if (!full_size && $urandom_range(4) == 0)
        begin
            // Reuse whatever operand words are already in place.
            m = $urandom_range(loaded_prefix(first_loaded));
            n = $urandom_range(loaded_prefix(second_loaded));
            multiply(length_field(m), length_field(n));
            return;
        end
        m       = full_size ? MAX_WORDS : pick_size();
        n       = full_size ? MAX_WORDS : pick_size();
        reverse = 1'($urandom_range(1));
        for (int k = 0; k < m; k++)
        begin
            idx = reverse ? m - 1 - k : k;
            load_word(KIND_LOAD_A, idx, pick_word());
        end
        if ($urandom_range(5) == 0)
            send_noise();
        for (int k = 0; k < n; k++)
        begin
            idx = reverse ? n - 1 - k : k;
            load_word(KIND_LOAD_B, idx, pick_word());
        end
        if ($urandom_range(7) == 0)
            load_word($urandom_range(1) ? KIND_LOAD_A : KIND_LOAD_B,
                      $urandom_range(MAX_WORDS - 1), pick_word());
        // Now and then start on at most as many first-operand words as were just loaded.
        if ($urandom_range(7) == 0)
            m = $urandom_range(m);
        multiply(length_field(m), length_field(n));
    endtask

    task automatic run_phase(int unsigned idle_pct, int unsigned item_goal);
        sender_idle_pct = idle_pct;
        while (items_sent < item_goal)
        begin
            run_sequence(sequence_count % 9 == 1);
            sequence_count++;
        end
        wait_drained();
    endtask

    initial
    begin
        #(12 * 600000);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n           <= 1'b0;
        start           <= 1'b0;
        command         <= '0;
        first_loaded     = '0;
        second_loaded    = '0;
        sender_idle_pct  = 0;
        items_sent       = 0;
        sequence_count   = 0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty product, then all-ones operands for the longest carry ripples.
        multiply(5'd0, 5'd0);
        load_word(KIND_LOAD_A, 0, '1);
        load_word(KIND_LOAD_B, 0, '1);
        multiply(5'd1, 5'd1);
        multiply(5'd1, 5'd0);
        multiply(5'd0, 5'd1);
        load_word(KIND_LOAD_A, 1, '1);
        load_word(KIND_LOAD_B, 1, '1);
        multiply(5'd2, 5'd2);
        send_noise();
        transfer('{kind: KIND_UNUSED, word_index: '1, word_value: '1,
                   first_length: '1, second_length: '1});
        // A zero operand gives a product trimmed to length zero.
        load_word(KIND_LOAD_A, 0, '0);
        load_word(KIND_LOAD_A, 1, '0);
        multiply(5'd2, 5'd1);
        load_word(KIND_LOAD_A, 1, 32'h0000_0001);
        load_word(KIND_LOAD_B, 0, '0);
        multiply(5'd2, 5'd2);
        load_word(KIND_LOAD_B, 1, 32'h8000_0000);
        load_word(KIND_LOAD_A, 0, 32'h0000_0001);
        multiply(5'd1, 5'd2);
        load_word(KIND_LOAD_A, MAX_WORDS - 1, '1);
        load_word(KIND_LOAD_B, MAX_WORDS - 1, '0);
        wait_drained();

        run_phase(18, 60);
        run_phase(73, 110);
        run_phase(0, 160);

        repeat (40)
            @(posedge clk);
        if (tracker.pending_words.size() != 0)
        begin
            $error("%0d product words never arrived", tracker.pending_words.size());
            tracker.mismatches++;
        end
        if (tracker.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
